>>> rtl/ssjb_pkg.sv
`default_nettype none
package ssjb_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int ID_WIDTH_DEF    = 32;

  localparam int SEQ_W  = 32;
  localparam int PAY_W  = 32;
  localparam int FILL_W = 7;
  localparam int STAT_W = 2;

  localparam logic [FILL_W-1:0] MIN_FILL_RESET = FILL_W'(4);

  typedef enum logic [0:0] {
    REQ_INSERT   = 1'b0,
    REQ_RETRIEVE = 1'b1
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_RETRIEVED = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_POP,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/ssjb_in_if.sv
`default_nettype none
interface ssjb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [ssjb_pkg::SEQ_W-1:0]  seq_id;
  logic [ssjb_pkg::PAY_W-1:0]  payload_handle;

  modport source (output valid, req_type, seq_id, payload_handle, input ready);
  modport sink   (input valid, req_type, seq_id, payload_handle, output ready);
endinterface
`default_nettype wire

>>> rtl/ssjb_out_if.sv
`default_nettype none
interface ssjb_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssjb_pkg::STAT_W-1:0] status;
  logic [ssjb_pkg::SEQ_W-1:0]  out_seq_id;
  logic [ssjb_pkg::PAY_W-1:0]  out_payload;
  logic [ssjb_pkg::FILL_W-1:0] fill;

  modport source (output valid, status, out_seq_id, out_payload, fill, input ready);
  modport sink   (input valid, status, out_seq_id, out_payload, fill, output ready);
endinterface
`default_nettype wire

>>> rtl/ssjb_ring.sv
`default_nettype none
// Entry store addressed by sorted position; position 0 sits at the head slot.
module ssjb_ring #(
  parameter int QUEUE_DEPTH = ssjb_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = ssjb_pkg::ID_WIDTH_DEF,
  localparam int AW         = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic [AW-1:0]              head,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_idx,
  output logic      [ID_WIDTH-1:0]        rd_id,
  output logic      [ssjb_pkg::PAY_W-1:0] rd_pay,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_idx,
  input  wire logic [ID_WIDTH-1:0]        wr_id,
  input  wire logic [ssjb_pkg::PAY_W-1:0] wr_pay
);

  localparam logic [AW:0] DEPTH_W = (AW+1)'(QUEUE_DEPTH);

  logic [ID_WIDTH-1:0]        mem_id  [QUEUE_DEPTH];
  logic [ssjb_pkg::PAY_W-1:0] mem_pay [QUEUE_DEPTH];

  logic [AW:0]   rd_sum;
  logic [AW:0]   wr_sum;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // wrap head + position back into the array
  always_comb begin
    rd_sum = {1'b0, head} + {1'b0, rd_idx};
    wr_sum = {1'b0, head} + {1'b0, wr_idx};
    if (rd_sum >= DEPTH_W) begin
      rd_sum = rd_sum - DEPTH_W;
    end
    if (wr_sum >= DEPTH_W) begin
      wr_sum = wr_sum - DEPTH_W;
    end
    rd_addr = rd_sum[AW-1:0];
    wr_addr = wr_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]  <= wr_id;
      mem_pay[wr_addr] <= wr_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id  <= mem_id[rd_addr];
      rd_pay <= mem_pay[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/sequence_sorted_jitter_buffer_top.sv
`default_nettype none
// Channel   Dir  Handshake       Word
// in_chan   in   valid/ready     req_type, seq_id, payload_handle
// out_chan  out  valid/ready     status, out_seq_id, out_payload, fill
// cfg_*     in   cfg_we strobe   cfg_wdata = min_fill
//
// One word in flight. Insert: one memory read/write per shifted entry, i.e. per
// held entry with a larger id; an insert into an empty buffer or a drop goes
// straight to S_DONE. Retrieve: a pop passes through S_POP, not ready does not.
// The sorted order lives in a ring; pop advances the head, no shifting.
// Reset clears fill, head and the draining flag; the entry store is not cleared.
// A new word is taken while a finished result still waits on out_chan; the
// block holds in its final stage until the output register frees.
module sequence_sorted_jitter_buffer_top #(
  parameter int QUEUE_DEPTH = ssjb_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = ssjb_pkg::ID_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ssjb_in_if.sink                          in_chan,
  ssjb_out_if.source                       out_chan,
  input  wire logic                        cfg_we,
  input  wire logic [ssjb_pkg::FILL_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = (CW > ssjb_pkg::FILL_W) ? CW : ssjb_pkg::FILL_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  ssjb_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 head_r, head_nxt;
  logic                          drain_r, drain_nxt;
  logic [AW-1:0]                 pos_r, pos_nxt;
  logic [ssjb_pkg::FILL_W-1:0]   min_fill_r;
  logic [ID_WIDTH-1:0]           id_r, id_nxt;
  logic [ssjb_pkg::PAY_W-1:0]    pay_r, pay_nxt;
  ssjb_pkg::status_t             res_status_r, res_status_nxt;
  logic [ID_WIDTH-1:0]           res_id_r, res_id_nxt;
  logic [ssjb_pkg::PAY_W-1:0]    res_pay_r, res_pay_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [ssjb_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [ssjb_pkg::SEQ_W-1:0]    out_id_r, out_id_nxt;
  logic [ssjb_pkg::PAY_W-1:0]    out_pay_r, out_pay_nxt;
  logic [ssjb_pkg::FILL_W-1:0]   out_fill_r, out_fill_nxt;

  logic                          accept;
  logic                          is_insert;
  logic                          full;
  logic                          empty;
  logic                          drain_next;
  logic                          pop;
  logic                          out_free;
  logic                          shift;

  logic                          rd_en;
  logic [AW-1:0]                 rd_idx;
  logic [ID_WIDTH-1:0]           rd_id;
  logic [ssjb_pkg::PAY_W-1:0]    rd_pay;
  logic                          wr_en;
  logic [AW-1:0]                 wr_idx;
  logic [ID_WIDTH-1:0]           wr_id;
  logic [ssjb_pkg::PAY_W-1:0]    wr_pay;

  assign in_chan.ready = (state_r == ssjb_pkg::S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_insert     = (in_chan.req_type == ssjb_pkg::REQ_INSERT);
  assign full          = (count_r == FULL_CNT);
  assign empty         = (count_r == '0);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign shift         = (rd_id > id_r);

  // draining flag as seen by a retrieve arriving now
  always_comb begin
    drain_next = drain_r;
    if (!drain_r) begin
      if (MW'(count_r) >= MW'(min_fill_r)) begin
        drain_next = 1'b1;
      end
    end else if (empty) begin
      drain_next = 1'b0;
    end
  end
  assign pop = drain_next && !empty;

  ssjb_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_ring (
    .clk    (clk),
    .head   (head_r),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rd_id  (rd_id),
    .rd_pay (rd_pay),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_id  (wr_id),
    .wr_pay (wr_pay)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssjb_pkg::S_IDLE: begin
        if (accept) begin
          if (is_insert) begin
            state_nxt = (full || empty) ? ssjb_pkg::S_DONE : ssjb_pkg::S_INS_CMP;
          end else begin
            state_nxt = pop ? ssjb_pkg::S_POP : ssjb_pkg::S_DONE;
          end
        end
      end
      ssjb_pkg::S_INS_CMP: begin
        if (!shift) begin
          state_nxt = ssjb_pkg::S_DONE;
        end else if (pos_r == AW'(1)) begin
          state_nxt = ssjb_pkg::S_INS_PUT;
        end
      end
      ssjb_pkg::S_INS_PUT: state_nxt = ssjb_pkg::S_DONE;
      ssjb_pkg::S_POP:     state_nxt = ssjb_pkg::S_DONE;
      ssjb_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = ssjb_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssjb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    head_nxt       = head_r;
    drain_nxt      = drain_r;
    pos_nxt        = pos_r;
    id_nxt         = id_r;
    pay_nxt        = pay_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_pay_nxt    = res_pay_r;
    rd_en          = 1'b0;
    rd_idx         = '0;
    wr_en          = 1'b0;
    wr_idx         = pos_r;
    wr_id          = id_r;
    wr_pay         = pay_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_pay_nxt    = out_pay_r;
    out_fill_nxt   = out_fill_r;

    unique case (state_r)
      ssjb_pkg::S_IDLE: begin
        if (accept) begin
          id_nxt      = in_chan.seq_id[ID_WIDTH-1:0];
          pay_nxt     = in_chan.payload_handle;
          res_id_nxt  = '0;
          res_pay_nxt = '0;
          if (is_insert) begin
            if (full) begin
              res_status_nxt = ssjb_pkg::ST_DROPPED;
            end else if (empty) begin
              wr_en          = 1'b1;
              wr_idx         = '0;
              wr_id          = in_chan.seq_id[ID_WIDTH-1:0];
              wr_pay         = in_chan.payload_handle;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = ssjb_pkg::ST_INSERTED;
            end else begin
              // fetch the current tail to compare against
              rd_en   = 1'b1;
              rd_idx  = count_r[AW-1:0] - AW'(1);
              pos_nxt = count_r[AW-1:0];
            end
          end else begin
            drain_nxt = drain_next;
            if (pop) begin
              rd_en  = 1'b1;
              rd_idx = '0;
            end else begin
              res_status_nxt = ssjb_pkg::ST_NOT_READY;
            end
          end
        end
      end
      ssjb_pkg::S_INS_CMP: begin
        if (shift) begin
          // move the larger entry up one slot, fetch the next one down
          wr_en   = 1'b1;
          wr_idx  = pos_r;
          wr_id   = rd_id;
          wr_pay  = rd_pay;
          pos_nxt = pos_r - AW'(1);
          if (pos_r != AW'(1)) begin
            rd_en  = 1'b1;
            rd_idx = pos_r - AW'(2);
          end
        end else begin
          wr_en          = 1'b1;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ssjb_pkg::ST_INSERTED;
        end
      end
      ssjb_pkg::S_INS_PUT: begin
        wr_en          = 1'b1;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = ssjb_pkg::ST_INSERTED;
      end
      ssjb_pkg::S_POP: begin
        res_status_nxt = ssjb_pkg::ST_RETRIEVED;
        res_id_nxt     = rd_id;
        res_pay_nxt    = rd_pay;
        head_nxt       = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
        count_nxt      = count_r - CW'(1);
      end
      ssjb_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = ssjb_pkg::SEQ_W'(res_id_r);
          out_pay_nxt    = res_pay_r;
          out_fill_nxt   = ssjb_pkg::FILL_W'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssjb_pkg::S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      drain_r     <= 1'b0;
      min_fill_r  <= ssjb_pkg::MIN_FILL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_fill_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    id_r         <= id_nxt;
    pay_r        <= pay_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_pay_r    <= out_pay_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.out_seq_id  = out_id_r;
  assign out_chan.out_payload = out_pay_r;
  assign out_chan.fill        = out_fill_r;

endmodule
`default_nettype wire
